// ===== rtl/lphs_pkg.sv =====
// package for the linear probe hash set: sizes, codes and request/response types
// no dependencies; used by linear_probe_hash_set and the testbench
package lphs_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int ADDR_W    = $clog2(MAX_SLOTS);
  localparam int SIZE_W    = ADDR_W + 1;
  localparam int KEY_W     = 32;
  localparam int CNT_W     = 11;
  localparam int CFG_W     = 11;
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = KEY_W / MOD_BITS;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_ZERO = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_SEEK,
    S_PROBE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [1:0]       status;
    logic [CNT_W-1:0] element_count;
  } rsp_t;

endpackage

// ===== rtl/lphs_ram.sv =====
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module lphs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/linear_probe_hash_set.sv =====
// linear probe hash set: insert / lookup / clear of nonzero 32-bit keys
// insert and lookup: key mod size, a read setup, a read per probed slot, then the response
// clear: one slot per cycle over all slots, then the response
// one request at a time; the next request is taken while the last response waits
// after rst (synchronous) a clearing pass over all MAX_SLOTS slots runs with req_stall high
// depends on lphs_pkg and lphs_ram
module linear_probe_hash_set (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lphs_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  lphs_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output lphs_pkg::rsp_t             rsp
);

  localparam int AW = lphs_pkg::ADDR_W;
  localparam int SW = lphs_pkg::SIZE_W;
  localparam int KW = lphs_pkg::KEY_W;
  localparam int MB = lphs_pkg::MOD_BITS;

  lphs_pkg::state_t state, state_next;

  // table size in use, already clamped to [2, MAX_SLOTS]
  logic [SW-1:0] size_q;
  logic [lphs_pkg::CNT_W-1:0] count;

  // request being worked on
  logic [KW-1:0] key_q;
  logic [KW-1:0] kshift;
  logic          op_ins;

  // modulo unit
  logic [AW-1:0]                  rem, rem_next;
  logic [lphs_pkg::MOD_CNT_W-1:0] mod_cnt;
  logic                           mod_last;

  // probe walk
  logic [AW-1:0] idx, idx_next;
  logic [SW-1:0] probe_n;
  logic [SW-1:0] idx_inc;
  logic          hit_empty, hit_key, probe_last, probe_done;

  // clearing sweep
  logic [AW-1:0] sweep;
  logic          sweep_last;
  logic          clr_rsp;

  // pending result
  logic                  res_found;
  lphs_pkg::status_t     res_status;
  logic                  rsp_free;

  // slot memory
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [KW-1:0] mem_wdata, mem_rdata;

  lphs_ram #(
    .WIDTH (KW),
    .DEPTH (lphs_pkg::MAX_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ---- combinational helpers ----

  // four restoring steps of the remainder per cycle, msb of key first
  always_comb begin
    logic [SW-1:0] t;
    logic [AW-1:0] r;
    r = rem;
    for (int i = 0; i < MB; i++) begin
      t = {r, kshift[KW-1-i]};
      if (t >= size_q) begin
        t = t - size_q;
      end
      r = t[AW-1:0];
    end
    rem_next = r;
  end

  assign mod_last   = (mod_cnt == lphs_pkg::MOD_CNT_W'(lphs_pkg::MOD_STEPS - 1));
  assign sweep_last = (sweep == AW'(lphs_pkg::MAX_SLOTS - 1));

  // wrap at the size in use
  assign idx_inc  = {1'b0, idx} + SW'(1);
  assign idx_next = (idx_inc == size_q) ? '0 : idx_inc[AW-1:0];

  assign hit_empty  = (mem_rdata == '0);
  assign hit_key    = (mem_rdata == key_q);
  assign probe_last = (SW'(probe_n + SW'(1)) == size_q);
  assign probe_done = hit_empty || hit_key || probe_last;

  // output register can take a new response
  assign rsp_free = !rsp_valid || !rsp_stall;

  // ---- next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      lphs_pkg::S_CLEAR: begin
        if (sweep_last) begin
          state_next = clr_rsp ? lphs_pkg::S_RESP : lphs_pkg::S_IDLE;
        end
      end
      lphs_pkg::S_IDLE: begin
        if (req_valid) begin
          if (req.opcode == lphs_pkg::OP_CLEAR) begin
            state_next = lphs_pkg::S_CLEAR;
          end else if ((req.opcode == lphs_pkg::OP_INSERT ||
                        req.opcode == lphs_pkg::OP_LOOKUP) &&
                       req.key != '0 &&
                       !(req.opcode == lphs_pkg::OP_INSERT &&
                         32'(count) > 32'(size_q >> 1))) begin
            state_next = lphs_pkg::S_MOD;
          end else begin
            state_next = lphs_pkg::S_RESP;
          end
        end
      end
      lphs_pkg::S_MOD: begin
        if (mod_last) begin
          state_next = lphs_pkg::S_SEEK;
        end
      end
      lphs_pkg::S_SEEK:  state_next = lphs_pkg::S_PROBE;
      lphs_pkg::S_PROBE: begin
        if (probe_done) begin
          state_next = lphs_pkg::S_RESP;
        end
      end
      lphs_pkg::S_RESP: begin
        if (rsp_free) begin
          state_next = lphs_pkg::S_IDLE;
        end
      end
      default: state_next = lphs_pkg::S_IDLE;
    endcase
  end

  // ---- outputs: memory ports and request stall ----
  always_comb begin
    req_stall = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = key_q;
    mem_re    = 1'b0;
    mem_raddr = idx;
    unique case (state)
      lphs_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep;
        mem_wdata = '0;
      end
      lphs_pkg::S_IDLE:  req_stall = 1'b0;
      lphs_pkg::S_SEEK:  mem_re = 1'b1;
      lphs_pkg::S_PROBE: begin
        // stream the next slot read while this one is checked
        if (!probe_done) begin
          mem_re    = 1'b1;
          mem_raddr = idx_next;
        end
        // first empty slot on insert takes the key
        if (op_ins && hit_empty) begin
          mem_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lphs_pkg::S_CLEAR;
      sweep     <= '0;
      clr_rsp   <= 1'b0;
      count     <= '0;
      size_q    <= SW'(lphs_pkg::MAX_SLOTS);
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;

      // size register, clamped on write
      if (cfg_we) begin
        if (cfg_wdata < lphs_pkg::CFG_W'(2)) begin
          size_q <= SW'(2);
        end else if (32'(cfg_wdata) > lphs_pkg::MAX_SLOTS) begin
          size_q <= SW'(lphs_pkg::MAX_SLOTS);
        end else begin
          size_q <= SW'(cfg_wdata);
        end
      end

      // response register: loaded in the response state, emptied when taken
      if (state == lphs_pkg::S_RESP && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        lphs_pkg::S_CLEAR: begin
          sweep <= sweep + AW'(1);
        end
        lphs_pkg::S_IDLE: begin
          if (req_valid) begin
            key_q      <= req.key;
            kshift     <= req.key;
            op_ins     <= (req.opcode == lphs_pkg::OP_INSERT);
            rem        <= '0;
            mod_cnt    <= '0;
            probe_n    <= '0;
            res_found  <= 1'b0;
            res_status <= lphs_pkg::STAT_OK;
            unique case (req.opcode) inside
              lphs_pkg::OP_CLEAR: begin
                sweep   <= '0;
                clr_rsp <= 1'b1;
                count   <= '0;
              end
              lphs_pkg::OP_INSERT, lphs_pkg::OP_LOOKUP: begin
                if (req.key == '0) begin
                  res_status <= lphs_pkg::STAT_ZERO;
                end else if (req.opcode == lphs_pkg::OP_INSERT &&
                             32'(count) > 32'(size_q >> 1)) begin
                  // over half full: refused before any probe
                  res_status <= lphs_pkg::STAT_FULL;
                end
              end
              default: ;
            endcase
          end
        end
        lphs_pkg::S_MOD: begin
          rem     <= rem_next;
          kshift  <= kshift << MB;
          mod_cnt <= mod_cnt + lphs_pkg::MOD_CNT_W'(1);
          if (mod_last) begin
            idx <= rem_next;
          end
        end
        lphs_pkg::S_PROBE: begin
          if (probe_done) begin
            res_found <= hit_key;
            if (op_ins && !hit_empty && !hit_key) begin
              res_status <= lphs_pkg::STAT_FULL;
            end
            if (op_ins && hit_empty) begin
              count <= count + lphs_pkg::CNT_W'(1);
            end
          end else begin
            idx     <= idx_next;
            probe_n <= probe_n + SW'(1);
          end
        end
        lphs_pkg::S_RESP: begin
          if (rsp_free) begin
            rsp.found         <= res_found;
            rsp.status        <= res_status;
            rsp.element_count <= count;
            clr_rsp           <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  // reset always starts the clearing pass, so no request is taken right after it
  a_reset_sweep: assert property (@(posedge clk) rst |=> req_stall)
    else $error("request accepted during the clearing pass");

  // a probe walk never runs past the size in use
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == lphs_pkg::S_PROBE) |-> (probe_n < size_q))
    else $error("probe walk went past the table size");

  // a key is only written into an empty slot
  a_write_empty: assert property (@(posedge clk) disable iff (rst)
    (state == lphs_pkg::S_PROBE && mem_we) |-> (mem_rdata == '0))
    else $error("key written over an occupied slot");

  // the count never exceeds half the largest table plus one
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= (lphs_pkg::MAX_SLOTS / 2 + 1))
    else $error("element count out of range");

  // a hit never comes with an error status
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.found) |-> (rsp.status == lphs_pkg::STAT_OK))
    else $error("found reported with error status");
`endif

endmodule

// ===== tb/linear_probe_hash_set_checker.sv =====
// request/response checker for linear_probe_hash_set: predicts each response from a shadow table
// watches the config port and both channels; depends on lphs_pkg
module linear_probe_hash_set_checker
  import lphs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             req_valid,
  input  logic             req_stall,
  input  req_t             req,
  input  logic             rsp_valid,
  input  logic             rsp_stall,
  input  rsp_t             rsp,
  input  logic             run_done,
  output int               failures
);

  // shadow of the slot table, key count and size register
  logic [KEY_W-1:0] shadow_slots [MAX_SLOTS];
  logic [CNT_W-1:0] shadow_count;
  logic [CFG_W-1:0] shadow_size;

  rsp_t expected_rsps [$];
  int   mismatch_count = 0;
  bit   leftovers_checked = 1'b0;

  assign failures = mismatch_count;

  function automatic rsp_t apply_set_op(req_t r);
    int unsigned span;
    int unsigned idx;
    int unsigned n;
    bit   hit;
    bit   hole;
    rsp_t res;
    res  = '0;
    hit  = 1'b0;
    hole = 1'b0;
    span = shadow_size;
    if (span < 2) span = 2;
    if (span > MAX_SLOTS) span = MAX_SLOTS;
    case (r.opcode) inside
      OP_CLEAR: begin
        foreach (shadow_slots[i]) shadow_slots[i] = '0;
        shadow_count = '0;
      end
      OP_INSERT, OP_LOOKUP: begin
        if (r.key == '0) begin
          res.status = STAT_ZERO;
        end else if (r.opcode == OP_INSERT && shadow_count > span / 2) begin
          res.status = STAT_FULL;
        end else begin
          idx = r.key % span;
          for (n = 0; n < span && !hit && !hole; n++) begin
            if (shadow_slots[idx] == '0) hole = 1'b1;
            else if (shadow_slots[idx] == r.key) hit = 1'b1;
            else idx = (idx + 1 == span) ? 0 : idx + 1;
          end
          if (r.opcode == OP_LOOKUP) begin
            res.found = hit;
          end else if (hit) begin
            res.found = 1'b1;
          end else if (hole) begin
            shadow_slots[idx] = r.key;
            shadow_count = shadow_count + 1'b1;
          end else begin
            res.status = STAT_FULL;
          end
        end
      end
      default: ;
    endcase
    res.element_count = shadow_count;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      foreach (shadow_slots[i]) shadow_slots[i] = '0;
      shadow_count = '0;
      shadow_size  = CFG_W'(MAX_SLOTS);
      expected_rsps.delete();
    end else begin
      if (cfg_we) shadow_size = cfg_wdata;
      // a response can never belong to a request taken at the same edge
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          mismatch_count++;
          $error("response with no request pending");
        end else begin
          want = expected_rsps.pop_front();
          check_field("found", want.found, rsp.found);
          check_field("status", want.status, rsp.status);
          check_field("element_count", want.element_count, rsp.element_count);
        end
      end
      if (req_valid && !req_stall) expected_rsps.push_back(apply_set_op(req));
      if (run_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_rsps.size() != 0) begin
          mismatch_count += expected_rsps.size();
          $error("%0d responses never arrived", expected_rsps.size());
        end
      end
    end
  end

endmodule

// ===== tb/linear_probe_hash_set_test.sv =====
// top of the linear_probe_hash_set test: clock, reset, request stimulus and verdict
// depends on lphs_pkg, linear_probe_hash_set and linear_probe_hash_set_checker
module linear_probe_hash_set_test;
  import lphs_pkg::*;

  // opcode the block has no use for; it must answer with no change
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int          PHASE_COUNT  = 12;
  localparam int          PHASE_ITEMS  = 120;
  localparam int          POOL_DEPTH   = 32;
  localparam int          DRAIN_CYCLES = 1100;
  localparam int unsigned CYCLE_LIMIT  = 8_000_000;

  logic             clk;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             req_valid = 1'b0;
  logic             req_stall;
  req_t             req       = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  rsp_t             rsp;
  logic             run_done  = 1'b0;
  logic             hold_off  = 1'b0;
  int               failures;

  // handshake counts seen by the stimulus side
  int req_sent    = 0;
  int rsps_taken  = 0;
  int unsigned cycle_count = 0;

  // keys already offered for insert, reused so lookups and duplicates hit
  logic [KEY_W-1:0] key_pool [POOL_DEPTH] = '{default: 32'd1};

  // size settings of the random phases: clamped low, odd, tiny, clamped high
  logic [CFG_W-1:0] phase_sizes [PHASE_COUNT] = '{
    11'd1, 11'd3, 11'd16, 11'd1025, 11'd5, 11'd64,
    11'd2, 11'd7, 11'd1024, 11'd200, 11'd33, 11'd4
  };

  // both sides idle at random except in one quiet window of requests
  wire noisy = !(req_sent >= 600 && req_sent < 850);

  linear_probe_hash_set u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  linear_probe_hash_set_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .run_done  (run_done),
    .failures  (failures)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // response side: random stalls plus the long hold-off
  always @(posedge clk) begin
    if (rsp_valid && !rsp_stall) rsps_taken++;
    rsp_stall <= hold_off || (noisy && $urandom_range(0, 99) < 17);
  end

  // long hold-off on responses while requests keep coming, so the block backs up
  initial begin
    wait (req_sent >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // offer one request, with random idle cycles ahead of it; valid stays high
  // after acceptance so a following request goes out back to back
  task automatic send_request(input logic [1:0] op, input logic [KEY_W-1:0] key);
    while (noisy && $urandom_range(0, 99) < 17) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{opcode: op, key: key};
    do @(posedge clk); while (req_stall);
    req_sent++;
  endtask

  // size register change, only once every response is back
  task automatic write_size(input logic [CFG_W-1:0] value);
    req_valid <= 1'b0;
    while (rsps_taken != req_sent) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // key mix: zero, earlier keys, small keys that collide, multiples of the
  // size plus zero to two that crowd the lowest home slots, and full-width random keys
  function automatic logic [KEY_W-1:0] pick_key(input int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 40) return key_pool[$urandom_range(0, POOL_DEPTH - 1)];
    if (r < 70) return $urandom_range(1, 3 * span);
    if (r < 82) return span * $urandom_range(1, 1000) + $urandom_range(0, 2);
    return $urandom();
  endfunction

  initial begin : stimulus
    int unsigned      span;
    int unsigned      r;
    logic [1:0]       op;
    logic [KEY_W-1:0] key;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset size of 1024
    send_request(OP_INSERT, 32'h0000_0000);   // zero key rejected
    send_request(OP_LOOKUP, 32'h0000_0000);
    send_request(OP_UNUSED, 32'hFFFF_FFFF);   // unused opcode, no change
    send_request(OP_LOOKUP, 32'hFFFF_FFFF);   // miss on empty table
    send_request(OP_INSERT, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'hFFFF_FFFF);   // already present
    send_request(OP_LOOKUP, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'd1024);        // home slot 0
    send_request(OP_INSERT, 32'd2048);        // collides, goes to slot 1
    send_request(OP_INSERT, 32'd1023);        // home is the last slot, taken; wraps to slot 2
    send_request(OP_INSERT, 32'd2047);        // probe wraps from the last slot
    send_request(OP_LOOKUP, 32'd2047);
    send_request(OP_CLEAR,  32'h5A5A_5A5A);   // key ignored on clear
    send_request(OP_LOOKUP, 32'd1023);

    // smallest table: fill it, then over half full and full-probe miss
    write_size(11'd2);
    send_request(OP_INSERT, 32'd2);
    send_request(OP_INSERT, 32'd3);
    send_request(OP_INSERT, 32'd5);           // refused, over half full
    send_request(OP_INSERT, 32'd3);           // refused even though present
    send_request(OP_LOOKUP, 32'd7);           // probes every slot, no hit
    send_request(OP_LOOKUP, 32'd3);

    // size zero clamps to two
    write_size(11'd0);
    send_request(OP_LOOKUP, 32'd2);

    // all ones clamps to the maximum; old keys sit away from their new home
    write_size(11'h7FF);
    send_request(OP_LOOKUP, 32'd3);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_LOOKUP, 32'h8000_0000);

    // random phases, one per size setting
    foreach (phase_sizes[p]) begin
      write_size(phase_sizes[p]);
      span = phase_sizes[p];
      if (span < 2) span = 2;
      if (span > MAX_SLOTS) span = MAX_SLOTS;
      repeat (PHASE_ITEMS) begin
        r   = $urandom_range(0, 99);
        key = pick_key(span);
        if (r < 3) op = OP_CLEAR;
        else if (r < 6) op = OP_UNUSED;
        else if (r < 55) op = OP_INSERT;
        else op = OP_LOOKUP;
        send_request(op, key);
        if (op == OP_INSERT && key != '0) key_pool[$urandom_range(0, POOL_DEPTH - 1)] = key;
      end
    end

    // drain, then give a stray response time to show up
    req_valid <= 1'b0;
    while (rsps_taken != req_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lphs_pkg.sv
rtl/lphs_ram.sv
rtl/linear_probe_hash_set.sv
tb/linear_probe_hash_set_checker.sv
tb/linear_probe_hash_set_test.sv
